FILE: hdl/twud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twud_pkg
// Types, constants and the CRC-16 byte update for the three-wire UART
// packet deframer.
// ----------------------------------------------------------------------------
package twud_pkg;

    localparam int CountW    = 13;
    localparam int LenW      = 12;
    localparam int FifoDepth = 4;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int FillW     = $clog2(FifoDepth + 1);

    localparam logic [CountW-1:0] COUNT_MAX = 13'd8191;
    localparam logic [CountW-1:0] HDR_LEN   = 13'd4;
    localparam logic [CountW-1:0] CRC_LEN   = 13'd2;
    localparam logic [15:0]       CRC_INIT  = 16'hFFFF;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_SHORT = 2'd1;
    localparam status_t STATUS_BAD   = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [7:0]      data_out;
        logic [2:0]      seq_number;
        logic [2:0]      ack_number;
        logic            reliable_flag;
        logic            crc_flag;
        logic [3:0]      type_out;
        logic [LenW-1:0] length_out;
        logic [7:0]      header_sum_out;
        status_t         status;
        logic            last_out;
    } result_t;

    // crc-16 ccitt style byte update, byte-swapped form
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]};
        c = c ^ {8'h00, data};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage

FILE: hdl/three_wire_uart_packet_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_uart_packet_deframer_top
// A payload word enters the result queue at the edge that takes its byte;
// when the final byte is also a payload byte, the status word enters behind
// it at the same edge. Throughput: one byte per cycle while the 4-entry
// result queue, which holds up to two words per byte, has room for two more.
// Reset: asynchronous, active low; clears the byte counter, crc and queue.
// ----------------------------------------------------------------------------
module three_wire_uart_packet_deframer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  byte_in,
    input  logic                        last_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        kind,
    output logic [7:0]                  data_out,
    output logic [2:0]                  seq_number,
    output logic [2:0]                  ack_number,
    output logic                        reliable_flag,
    output logic                        crc_flag,
    output logic [3:0]                  type_out,
    output logic [twud_pkg::LenW-1:0]   length_out,
    output logic [7:0]                  header_sum_out,
    output twud_pkg::status_t           status,
    output logic                        last_out
);
    import twud_pkg::*;

    // deframer state
    logic [CountW-1:0] byte_count_reg, byte_count_next;
    logic [7:0]        hdr_reg [3];
    logic [7:0]        hdr_next [3];
    logic [7:0]        hchk_reg, hchk_next;
    logic [15:0]       crc_reg, crc_next;
    logic [15:0]       rcrc_reg, rcrc_next;

    // result queue
    result_t           fifo_mem_reg [FifoDepth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FillW-1:0]  fill_reg, fill_next;

    logic              accept, pop;
    logic              is_payload, push_a, push_b;
    logic [CountW-1:0] len13, plen4, count_inc, expect_len;
    logic [LenW-1:0]   len_n;
    logic [7:0]        sum_n;
    logic              crc_on;
    status_t           st;
    result_t           payload_item, status_item, item_a;

    assign accept   = in_valid && in_ready;
    assign pop      = out_valid && out_ready;
    assign in_ready = (fill_reg <= FillW'(FifoDepth - 2));

    assign len13      = {1'b0, hdr_reg[2], hdr_reg[1][7:4]};
    assign plen4      = len13 + HDR_LEN;
    assign is_payload = (byte_count_reg >= HDR_LEN) && (byte_count_reg < plen4);
    assign count_inc  = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                      : byte_count_reg + 13'd1;

    always_comb
    begin
        hdr_next[0] = hdr_reg[0];
        hdr_next[1] = hdr_reg[1];
        hdr_next[2] = hdr_reg[2];
        hchk_next   = hchk_reg;
        crc_next    = crc_reg;
        rcrc_next   = rcrc_reg;
        if (byte_count_reg < 13'd3)
        begin
            hdr_next[byte_count_reg[1:0]] = byte_in;
            crc_next = crc_update(crc_reg, byte_in);
        end
        else if (byte_count_reg == 13'd3)
        begin
            hchk_next = byte_in;
            crc_next  = crc_update(crc_reg, byte_in);
        end
        else if (is_payload)
        begin
            crc_next = crc_update(crc_reg, byte_in);
        end
        else if (byte_count_reg == plen4)
        begin
            rcrc_next = {rcrc_reg[15:8], byte_in};
        end
        else if (byte_count_reg == plen4 + 13'd1)
        begin
            rcrc_next = {byte_in, rcrc_reg[7:0]};
        end
    end

    // end-of-packet checks on updated header and crc; queue and counter updates
    always_comb
    begin
        len_n      = {hdr_next[2], hdr_next[1][7:4]};
        crc_on     = hdr_next[0][6];
        expect_len = {1'b0, len_n} + HDR_LEN + (crc_on ? CRC_LEN : '0);
        sum_n      = 8'd0 - (hdr_next[0] + hdr_next[1] + hdr_next[2]);
        priority if (count_inc != expect_len)
            st = STATUS_BAD;
        else if (hchk_next != sum_n)
            st = STATUS_BAD;
        else if (crc_on && (rcrc_next != crc_next))
            st = STATUS_BAD;
        else
            st = STATUS_OK;

        status_item          = '0;
        status_item.kind     = KIND_STATUS;
        status_item.last_out = 1'b1;
        if (count_inc < HDR_LEN)
        begin
            status_item.status = STATUS_SHORT;
        end
        else
        begin
            status_item.seq_number     = hdr_next[0][2:0];
            status_item.ack_number     = hdr_next[0][5:3];
            status_item.reliable_flag  = hdr_next[0][7];
            status_item.crc_flag       = crc_on;
            status_item.type_out       = hdr_next[1][3:0];
            status_item.length_out     = len_n;
            status_item.header_sum_out = hchk_next;
            status_item.status         = st;
        end

        payload_item          = '0;
        payload_item.kind     = KIND_DATA;
        payload_item.data_out = byte_in;

        item_a = is_payload ? payload_item : status_item;
        push_a = accept && (is_payload || last_in);
        push_b = accept && is_payload && last_in;

        if (accept && last_in)
            byte_count_next = '0;
        else if (accept)
            byte_count_next = count_inc;
        else
            byte_count_next = byte_count_reg;

        wr_ptr_next = wr_ptr_reg + PtrW'(push_a) + PtrW'(push_b);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        fill_next   = fill_reg + FillW'(push_a) + FillW'(push_b) - FillW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            hdr_reg[0]     <= '0;
            hdr_reg[1]     <= '0;
            hdr_reg[2]     <= '0;
            hchk_reg       <= '0;
            crc_reg        <= CRC_INIT;
            rcrc_reg       <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fill_reg       <= fill_next;
            if (accept && last_in)
            begin
                hdr_reg[0] <= '0;
                hdr_reg[1] <= '0;
                hdr_reg[2] <= '0;
                hchk_reg   <= '0;
                crc_reg    <= CRC_INIT;
                rcrc_reg   <= '0;
            end
            else if (accept)
            begin
                hdr_reg[0] <= hdr_next[0];
                hdr_reg[1] <= hdr_next[1];
                hdr_reg[2] <= hdr_next[2];
                hchk_reg   <= hchk_next;
                crc_reg    <= crc_next;
                rcrc_reg   <= rcrc_next;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_a)
            fifo_mem_reg[wr_ptr_reg] <= item_a;
        if (push_b)
            fifo_mem_reg[wr_ptr_reg + PtrW'(1)] <= status_item;
    end

    assign out_valid      = (fill_reg != '0);
    assign kind           = fifo_mem_reg[rd_ptr_reg].kind;
    assign data_out       = fifo_mem_reg[rd_ptr_reg].data_out;
    assign seq_number     = fifo_mem_reg[rd_ptr_reg].seq_number;
    assign ack_number     = fifo_mem_reg[rd_ptr_reg].ack_number;
    assign reliable_flag  = fifo_mem_reg[rd_ptr_reg].reliable_flag;
    assign crc_flag       = fifo_mem_reg[rd_ptr_reg].crc_flag;
    assign type_out       = fifo_mem_reg[rd_ptr_reg].type_out;
    assign length_out     = fifo_mem_reg[rd_ptr_reg].length_out;
    assign header_sum_out = fifo_mem_reg[rd_ptr_reg].header_sum_out;
    assign status         = fifo_mem_reg[rd_ptr_reg].status;
    assign last_out       = fifo_mem_reg[rd_ptr_reg].last_out;

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FillW'(FifoDepth))
        else $error("result queue overfilled");

    // final byte returns the counter to the start of a packet
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_in |=> byte_count_reg == '0)
        else $error("byte counter not cleared after final byte");

    // status words end the packet, payload words carry no status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == last_out) && (kind || status == STATUS_OK))
        else $error("malformed result word");

endmodule

FILE: tb/sv/three_wire_uart_packet_deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_uart_packet_deframer_checker
// Watches both channels of the deframer. Every accepted byte is decoded with
// an independent copy of the header, length and crc state, which predicts the
// payload and status words. Each word that leaves the block is compared field
// by field with the oldest predicted word. Hands back a count of mismatches
// and of words still outstanding.
// ----------------------------------------------------------------------------
module three_wire_uart_packet_deframer_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [7:0]                  byte_in,
    input  logic                        last_in,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        kind,
    input  logic [7:0]                  data_out,
    input  logic [2:0]                  seq_number,
    input  logic [2:0]                  ack_number,
    input  logic                        reliable_flag,
    input  logic                        crc_flag,
    input  logic [3:0]                  type_out,
    input  logic [twud_pkg::LenW-1:0]   length_out,
    input  logic [7:0]                  header_sum_out,
    input  twud_pkg::status_t           status,
    input  logic                        last_out,
    output int                          fail_count,
    output int                          words_pending
);

    import twud_pkg::*;

    result_t           pending_words[$];
    result_t           seen;
    logic [CountW-1:0] rx_count;
    logic [7:0]        hdr_byte [3];
    logic [7:0]        hdr_check;
    logic [15:0]       crc_run;
    logic [15:0]       crc_got;
    int                mismatches;
    int                word_no;

    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] t;
        t = {acc[7:0], acc[15:8]} ^ {8'h00, b};
        t[3:0] = t[3:0] ^ t[7:4];
        t[15:12] = t[15:12] ^ t[3:0];
        t[12:5] = t[12:5] ^ t[7:0];
        return t;
    endfunction

    task automatic clear_state();
        rx_count = '0;
        hdr_byte[0] = 8'h00;
        hdr_byte[1] = 8'h00;
        hdr_byte[2] = 8'h00;
        hdr_check = 8'h00;
        crc_run = CRC_INIT;
        crc_got = 16'h0000;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("word %0d: %s got %0h expected %0h", word_no, what, got, want);
        mismatches = mismatches + 1;
    endtask

    task automatic compare_word(input result_t got, input result_t want);
        if (got.kind !== want.kind)
            report_mismatch("kind", got.kind, want.kind);
        if (got.data_out !== want.data_out)
            report_mismatch("data_out", got.data_out, want.data_out);
        if (got.seq_number !== want.seq_number)
            report_mismatch("seq_number", got.seq_number, want.seq_number);
        if (got.ack_number !== want.ack_number)
            report_mismatch("ack_number", got.ack_number, want.ack_number);
        if (got.reliable_flag !== want.reliable_flag)
            report_mismatch("reliable_flag", got.reliable_flag, want.reliable_flag);
        if (got.crc_flag !== want.crc_flag)
            report_mismatch("crc_flag", got.crc_flag, want.crc_flag);
        if (got.type_out !== want.type_out)
            report_mismatch("type_out", got.type_out, want.type_out);
        if (got.length_out !== want.length_out)
            report_mismatch("length_out", got.length_out, want.length_out);
        if (got.header_sum_out !== want.header_sum_out)
            report_mismatch("header_sum_out", got.header_sum_out, want.header_sum_out);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.last_out !== want.last_out)
            report_mismatch("last_out", got.last_out, want.last_out);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        result_t           w;
        logic [CountW-1:0] at;
        logic [CountW-1:0] body_end;
        logic [LenW-1:0]   plen;
        logic [7:0]        sum;
        int                want_total;
        at = rx_count;
        plen = {hdr_byte[2], hdr_byte[1][7:4]};
        body_end = HDR_LEN + {1'b0, plen};
        if (at < 3)
        begin
            hdr_byte[at] = b;
            crc_run = crc_byte(crc_run, b);
        end
        else if (at == 3)
        begin
            hdr_check = b;
            crc_run = crc_byte(crc_run, b);
        end
        else if (at < body_end)
        begin
            crc_run = crc_byte(crc_run, b);
            w = '0;
            w.kind = KIND_DATA;
            w.data_out = b;
            pending_words = {pending_words, w};
        end
        else if (at == body_end)
            crc_got[7:0] = b;
        else if (at == body_end + 1)
            crc_got[15:8] = b;
        if (rx_count != COUNT_MAX)
            rx_count = rx_count + 1'b1;
        if (fin)
        begin
            w = '0;
            w.kind = KIND_STATUS;
            w.last_out = 1'b1;
            if (rx_count < HDR_LEN)
                w.status = STATUS_SHORT;
            else
            begin
                plen = {hdr_byte[2], hdr_byte[1][7:4]};
                w.seq_number = hdr_byte[0][2:0];
                w.ack_number = hdr_byte[0][5:3];
                w.reliable_flag = hdr_byte[0][7];
                w.crc_flag = hdr_byte[0][6];
                w.type_out = hdr_byte[1][3:0];
                w.length_out = plen;
                w.header_sum_out = hdr_check;
                want_total = int'(plen) + 4 + (hdr_byte[0][6] ? 2 : 0);
                sum = 8'h00 - hdr_byte[0] - hdr_byte[1] - hdr_byte[2];
                if (int'(rx_count) != want_total || hdr_check != sum
                    || (hdr_byte[0][6] && crc_got != crc_run))
                    w.status = STATUS_BAD;
                else
                    w.status = STATUS_OK;
            end
            pending_words = {pending_words, w};
            clear_state();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            pending_words.delete();
            mismatches = 0;
            word_no = 0;
            fail_count <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_byte(byte_in, last_in);
            if (out_valid && out_ready)
            begin
                seen.kind = kind;
                seen.data_out = data_out;
                seen.seq_number = seq_number;
                seen.ack_number = ack_number;
                seen.reliable_flag = reliable_flag;
                seen.crc_flag = crc_flag;
                seen.type_out = type_out;
                seen.length_out = length_out;
                seen.header_sum_out = header_sum_out;
                seen.status = status;
                seen.last_out = last_out;
                if (pending_words.size() == 0)
                    report_mismatch("word with nothing expected, kind", seen.kind, 16'h0);
                else
                    compare_word(seen, pending_words.pop_front());
                word_no = word_no + 1;
            end
            fail_count <= mismatches;
            words_pending <= pending_words.size();
        end
    end

endmodule

FILE: tb/sv/three_wire_uart_packet_deframer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_uart_packet_deframer_top_tb
// Drives unescaped packets into the deframer: a few hand-built packets for
// short, checksum, crc, length and excess-byte cases, then random packets,
// mostly well formed with some damaged. Both channels idle and stall at
// random. The checker beside the block predicts and compares; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module three_wire_uart_packet_deframer_top_tb;

    import twud_pkg::*;

    localparam int RandomBytes = 770;
    localparam int CycleLimit  = 500000;

    typedef enum int {
        BREAK_SHORT,
        BREAK_CHECKSUM,
        BREAK_CRC,
        BREAK_TRUNCATE,
        BREAK_EXCESS,
        BREAK_NOISE
    } damage_t;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic [7:0]      byte_in;
    logic            last_in;
    logic            out_valid;
    logic            out_ready;
    logic            kind;
    logic [7:0]      data_out;
    logic [2:0]      seq_number;
    logic [2:0]      ack_number;
    logic            reliable_flag;
    logic            crc_flag;
    logic [3:0]      type_out;
    logic [LenW-1:0] length_out;
    logic [7:0]      header_sum_out;
    status_t         status;
    logic            last_out;
    int              fail_count;
    int              words_pending;

    logic [7:0]      frame[$];
    logic [7:0]      h0;
    bit              calm_in;
    bit              calm_out;
    damage_t         damage;
    int              stall_left;
    int              bytes_sent;
    int              random_start;
    int              n;
    int              k;
    int              cycles = 0;

    three_wire_uart_packet_deframer_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_in        (byte_in),
        .last_in        (last_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_out       (data_out),
        .seq_number     (seq_number),
        .ack_number     (ack_number),
        .reliable_flag  (reliable_flag),
        .crc_flag       (crc_flag),
        .type_out       (type_out),
        .length_out     (length_out),
        .header_sum_out (header_sum_out),
        .status         (status),
        .last_out       (last_out)
    );

    three_wire_uart_packet_deframer_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_in        (byte_in),
        .last_in        (last_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_out       (data_out),
        .seq_number     (seq_number),
        .ack_number     (ack_number),
        .reliable_flag  (reliable_flag),
        .crc_flag       (crc_flag),
        .type_out       (type_out),
        .length_out     (length_out),
        .header_sum_out (header_sum_out),
        .status         (status),
        .last_out       (last_out),
        .fail_count     (fail_count),
        .words_pending  (words_pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // bit-serial crc, msb first
    function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm_in || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        last_in  <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    // well-formed packet; crc appended when the header asks for it
    task automatic build_frame(input logic [7:0] head, input logic [3:0] ptype,
                               input int plen, input bit edge_fill);
        logic [11:0] len12;
        logic [7:0]  chk;
        logic [15:0] crc;
        len12 = plen[11:0];
        frame.delete();
        frame = {frame, head};
        frame = {frame, {len12[3:0], ptype}};
        frame = {frame, len12[11:4]};
        chk = 8'h00 - frame[0] - frame[1] - frame[2];
        frame = {frame, chk};
        for (int i = 0; i < plen; i++)
            frame = {frame, (edge_fill ? ((i % 2 == 1) ? 8'hFF : 8'h00) : 8'($urandom))};
        if (head[6])
        begin
            crc = CRC_INIT;
            foreach (frame[i])
                crc = crc_next(crc, frame[i]);
            frame = {frame, crc[7:0]};
            frame = {frame, crc[15:8]};
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        stall_left = 0;
        calm_out = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 149) == 0)
                calm_out = !calm_out;
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm_out && $urandom_range(0, 3) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        byte_in  <= 8'h00;
        last_in  <= 1'b0;
        bytes_sent = 0;
        calm_in = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short packets
        frame = {8'hFF};
        send_frame();
        frame = {8'h00, 8'h80};
        send_frame();
        // good, no crc, all header bits but crc set
        build_frame(8'hBF, 4'hF, 0, 1'b0);
        send_frame();
        // good with crc, payload extremes
        build_frame(8'h40, 4'h0, 2, 1'b1);
        send_frame();
        // header checksum wrong
        build_frame(8'h00, 4'h9, 0, 1'b0);
        frame[3] = frame[3] ^ 8'h01;
        send_frame();
        // excess byte gives a length error
        build_frame(8'h3F, 4'h5, 0, 1'b0);
        frame = {frame, 8'hA5};
        send_frame();
        // crc wrong
        build_frame(8'h40, 4'hA, 0, 1'b0);
        frame[frame.size() - 1] = frame[frame.size() - 1] ^ 8'h80;
        send_frame();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RandomBytes)
        begin
            calm_in = ($urandom_range(0, 4) == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
            h0 = 8'($urandom);
            build_frame(h0, 4'($urandom), n, 1'b0);
            if ($urandom_range(0, 9) < 3)
            begin
                damage = damage_t'($urandom_range(0, 5));
                case (damage)
                    BREAK_SHORT:
                    begin
                        frame.delete();
                        repeat ($urandom_range(1, 3))
                            frame = {frame, 8'($urandom)};
                    end
                    BREAK_CHECKSUM:
                        frame[3] = frame[3] ^ 8'($urandom_range(1, 255));
                    BREAK_CRC:
                    begin
                        k = h0[6] ? $urandom_range(4, frame.size() - 1) : 3;
                        frame[k] = frame[k] ^ 8'($urandom_range(1, 255));
                    end
                    BREAK_TRUNCATE:
                        repeat ($urandom_range(1, 3))
                            if (frame.size() > 1)
                                void'(frame.pop_back());
                    BREAK_EXCESS:
                        repeat ($urandom_range(1, 4))
                            frame = {frame, 8'($urandom)};
                    default:
                    begin
                        frame.delete();
                        repeat ($urandom_range(4, 12))
                            frame = {frame, 8'($urandom)};
                    end
                endcase
            end
            send_frame();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0 && words_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
hdl/twud_pkg.sv
hdl/three_wire_uart_packet_deframer_top.sv
tb/sv/three_wire_uart_packet_deframer_checker.sv
tb/sv/three_wire_uart_packet_deframer_top_tb.sv
